// ----- sv/sbta_pkg.sv -----
// Package for the saturating byte tuple ALU: operation codes, result kinds,
// pipeline payload types and the two-bit-per-step divider stage function.
// No dependencies.
`default_nettype none

package sbta_pkg;

  localparam logic [3:0] FN_ADD  = 4'd0;
  localparam logic [3:0] FN_SUB  = 4'd1;
  localparam logic [3:0] FN_MUL  = 4'd2;
  localparam logic [3:0] FN_DIV  = 4'd3;
  localparam logic [3:0] FN_REM  = 4'd4;
  localparam logic [3:0] FN_AND  = 4'd5;
  localparam logic [3:0] FN_OR   = 4'd6;
  localparam logic [3:0] FN_XOR  = 4'd7;
  localparam logic [3:0] FN_COMP = 4'd8;

  localparam logic [7:0] BYTE_MAX = 8'd255;

  // 8 quotient bits, two per stage
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEP   = 2;

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_QUOT,
    KIND_REM
  } res_kind_t;

  typedef struct packed {
    res_kind_t  kind;
    logic [7:0] fixed;
    logic       dz;
  } side_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] num;
    logic [7:0] dsr;
    logic [7:0] quo;
    logic [7:0] rem;
    side_t      side;
  } div_stage_t;

  // Restoring division, DIV_STEP bits of the dividend per call.
  function automatic div_stage_t div_advance(div_stage_t s);
    div_stage_t o;
    logic [8:0] part;
    o = s;
    for (int i = 0; i < DIV_STEP; i++) begin
      part  = {o.rem, o.num[7]};
      o.num = {o.num[6:0], 1'b0};
      if (part >= {1'b0, o.dsr}) begin
        o.rem = 8'(part - {1'b0, o.dsr});
        o.quo = {o.quo[6:0], 1'b1};
      end else begin
        o.rem = part[7:0];
        o.quo = {o.quo[6:0], 1'b0};
      end
    end
    return o;
  endfunction

  // Clamp a 34-bit signed value into 0..255.
  function automatic logic [7:0] clamp34(logic [33:0] x);
    logic [7:0] r;
    if (x[33]) begin
      r = 8'd0;
    end else if (|x[32:8]) begin
      r = BYTE_MAX;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sbta_div.sv -----
// Pipelined 8-bit by 8-bit unsigned divider, two quotient bits per stage.
// Carries a side payload alongside each beat. Depends on sbta_pkg.
`default_nettype none

module sbta_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  logic [7:0]     dividend,
  input  logic [7:0]     divisor,
  input  sbta_pkg::side_t side_in,
  output logic           out_vld,
  output logic [7:0]     quot,
  output logic [7:0]     rem,
  output sbta_pkg::side_t side_out
);
  import sbta_pkg::*;

  div_stage_t entry;
  div_stage_t stg_r   [DIV_STAGES];
  div_stage_t stg_nxt [DIV_STAGES];

  always_comb begin
    entry.vld  = in_vld;
    entry.num  = dividend;
    entry.dsr  = divisor;
    entry.quo  = 8'd0;
    entry.rem  = 8'd0;
    entry.side = side_in;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    div_stage_t src;
    div_stage_t adv;
    if (g == 0) begin : g_first
      assign src = entry;
    end else begin : g_next
      assign src = stg_r[g-1];
    end
    assign adv = div_advance(src);
    // drop the valid bit while in reset
    assign stg_nxt[g] = {adv.vld && rst_n, adv.num, adv.dsr, adv.quo, adv.rem, adv.side};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      stg_r[i] <= stg_nxt[i];
    end
  end

  assign out_vld  = stg_r[DIV_STAGES-1].vld;
  assign quot     = stg_r[DIV_STAGES-1].quo;
  assign rem      = stg_r[DIV_STAGES-1].rem;
  assign side_out = stg_r[DIV_STAGES-1].side;

endmodule

`default_nettype wire

// ----- sv/saturating_byte_tuple_alu_unit.sv -----
// Saturating byte tuple ALU: one element per beat, result clamped to 0..255.
// Each beat passes the input register, the decode register, the divider stages and the output register.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the divider: four stages of two quotient bits each.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
// Depends on sbta_pkg and sbta_div.
`default_nettype none

module saturating_byte_tuple_alu_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_func,
  input  logic [7:0]  in_element,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  output logic [7:0]  out_result,
  output logic        out_divide_by_zero
);
  import sbta_pkg::*;

  // stage 1: input register
  logic        s1_vld_r;
  logic [3:0]  s1_func_r;
  logic [7:0]  s1_elem_r;
  logic [31:0] s1_opnd_r;

  // stage 2: decoded operation, divider operands
  logic        s2_vld_r;
  side_t       s2_side_r, s2_side_nxt;
  logic [7:0]  s2_dvd_r;
  logic [7:0]  s2_dsr_r, s2_dsr_nxt;

  logic        out_valid_r;
  logic [7:0]  out_result_r, out_result_nxt;
  logic        out_dz_r;

  logic        a_neg, a_big, a_zero, div_ok;
  logic [31:0] mag;
  logic [33:0] v_ext, a_ext;
  logic [15:0] prod;
  logic [7:0]  mul_res;

  logic        dv_vld;
  logic [7:0]  dv_quot, dv_rem;
  side_t       dv_side;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    s1_func_r <= in_func;
    s1_elem_r <= in_element;
    s1_opnd_r <= in_operand;
  end

  always_comb begin
    a_neg  = s1_opnd_r[31];
    a_zero = (s1_opnd_r == 32'd0);
    a_big  = !s1_opnd_r[31] && (|s1_opnd_r[30:8]);
    mag    = a_neg ? (~s1_opnd_r + 32'd1) : s1_opnd_r;
    div_ok = !a_zero && (mag[31:8] == 24'd0);
    v_ext  = {26'd0, s1_elem_r};
    a_ext  = {{2{s1_opnd_r[31]}}, s1_opnd_r};
    prod   = s1_elem_r * s1_opnd_r[7:0];

    // non-positive multiplier gives zero; a large one saturates any nonzero element
    if (a_neg || a_zero) begin
      mul_res = 8'd0;
    end else if (a_big) begin
      mul_res = (s1_elem_r == 8'd0) ? 8'd0 : BYTE_MAX;
    end else if (|prod[15:8]) begin
      mul_res = BYTE_MAX;
    end else begin
      mul_res = prod[7:0];
    end

    s2_side_nxt.kind  = KIND_FIXED;
    s2_side_nxt.fixed = s1_elem_r;
    s2_side_nxt.dz    = 1'b0;
    s2_dsr_nxt        = mag[7:0];

    case (s1_func_r)
      FN_ADD: s2_side_nxt.fixed = clamp34(v_ext + a_ext);
      FN_SUB: s2_side_nxt.fixed = clamp34(v_ext - a_ext);
      FN_MUL: s2_side_nxt.fixed = mul_res;
      FN_DIV: begin
        // negative divisor gives a non-positive quotient, which clamps to zero
        s2_side_nxt.fixed = 8'd0;
        s2_side_nxt.dz    = a_zero;
        if (div_ok && !a_neg) begin
          s2_side_nxt.kind = KIND_QUOT;
        end
      end
      FN_REM: begin
        // remainder takes the dividend's sign, so only the magnitude matters
        if (a_zero) begin
          s2_side_nxt.fixed = 8'd0;
          s2_side_nxt.dz    = 1'b1;
        end else if (div_ok) begin
          s2_side_nxt.kind = KIND_REM;
        end
      end
      FN_AND: s2_side_nxt.fixed = s1_elem_r & s1_opnd_r[7:0];
      FN_OR: begin
        if (a_neg) begin
          s2_side_nxt.fixed = 8'd0;
        end else if (a_big) begin
          s2_side_nxt.fixed = BYTE_MAX;
        end else begin
          s2_side_nxt.fixed = s1_elem_r | s1_opnd_r[7:0];
        end
      end
      FN_XOR: begin
        if (a_neg) begin
          s2_side_nxt.fixed = 8'd0;
        end else if (a_big) begin
          s2_side_nxt.fixed = BYTE_MAX;
        end else begin
          s2_side_nxt.fixed = s1_elem_r ^ s1_opnd_r[7:0];
        end
      end
      FN_COMP: s2_side_nxt.fixed = ~s1_elem_r;
      default: s2_side_nxt.fixed = s1_elem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_side_r <= s2_side_nxt;
    s2_dvd_r  <= s1_elem_r;
    s2_dsr_r  <= s2_dsr_nxt;
  end

  sbta_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s2_vld_r),
    .dividend (s2_dvd_r),
    .divisor  (s2_dsr_r),
    .side_in  (s2_side_r),
    .out_vld  (dv_vld),
    .quot     (dv_quot),
    .rem      (dv_rem),
    .side_out (dv_side)
  );

  always_comb begin
    case (dv_side.kind)
      KIND_QUOT: out_result_nxt = dv_quot;
      KIND_REM:  out_result_nxt = dv_rem;
      default:   out_result_nxt = dv_side.fixed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
    out_result_r <= out_result_nxt;
    out_dz_r     <= dv_side.dz;
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_divide_by_zero = out_dz_r;

endmodule

`default_nettype wire
